// ===== rtl/core/bls_pkg.sv =====
// Shared types, constants and the character map for the bigram scorer.
// No dependencies; used by all modules in rtl/core.
package bls_pkg;

  localparam int IDX_W     = 5;   // letter index, also table_row / table_col width
  localparam int CMP_W     = 7;   // wide enough to compare an index against ALPHABET
  localparam int SUM_W     = 32;  // running line sum
  localparam int DIV_CNT_W = 6;   // holds SUM_W
  localparam int FIELD_W   = 16;  // fixed width of both result fields
  localparam int VALUE_W   = 16;  // fixed width of table_value

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCORE = 1'b1;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [IDX_W-1:0] IDX_SPACE = 5'd26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } char_hit_t;

  // Case-folding map: letters to 0..25, space to 26, everything else misses.
  function automatic char_hit_t char_lookup(input logic [7:0] code);
    char_hit_t r;
    r.hit = 1'b0;
    r.idx = '0;
    if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
      r.hit = 1'b1;
      r.idx = IDX_W'(code - CHAR_UPPER_A);
    end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      r.hit = 1'b1;
      r.idx = IDX_W'(code - CHAR_LOWER_A);
    end else if (code == CHAR_SPACE) begin
      r.hit = 1'b1;
      r.idx = IDX_SPACE;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bls_table_ram.sv =====
// Single-port synchronous RAM holding the bigram log-probability table.
// Uses bls_pkg for the access control struct.
module bls_table_ram #(
  parameter int DEPTH  = 729,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  bls_pkg::ram_ctl_t ctl,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bls_divider.sv =====
// Restoring divider, one quotient bit per cycle: signed line sum over unsigned count,
// truncated toward zero. Uses bls_pkg for widths and the status struct.
module bls_divider #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [bls_pkg::SUM_W-1:0] dividend,
  input  logic [COUNT_WIDTH-1:0]           divisor,
  output bls_pkg::div_sts_t                sts,
  output logic signed [bls_pkg::SUM_W-1:0] quotient
);

  localparam int SW = bls_pkg::SUM_W;

  logic [bls_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          done_r;
  logic                          neg_r;
  logic [SW-1:0]                 quo_r;
  logic [COUNT_WIDTH-1:0]        rem_r;
  logic [COUNT_WIDTH-1:0]        dvs_r;
  logic [COUNT_WIDTH:0]          trial;
  logic [COUNT_WIDTH:0]          diff;
  logic                          fits;
  logic [SW-1:0]                 mag;

  assign mag   = dividend[SW-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r, quo_r[SW-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= bls_pkg::DIV_CNT_W'(SW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == bls_pkg::DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[SW-1];
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[SW-2:0], fits};
      rem_r <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
    end
  end

  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign sts.busy = cnt_r != '0;
  assign sts.done = done_r;

endmodule

// ===== rtl/core/bigram_log_prob_scorer.sv =====
// Top level of the bigram log-probability line scorer.
// Depends on bls_pkg, bls_table_ram and bls_divider.
//
// Words are taken one at a time. A table write (tuser = 0) is latched and then
// written to the table RAM. A scored character that closes a transition reads its
// table entry from the single-port table RAM, through its registered read, before
// the saturating add. A character with tlast set then runs the restoring divider
// for the line average before the result is loaded into the output register; the
// next word is accepted while that result waits for out_tready. Table entries are
// not cleared by reset and must be written before use.
module bigram_log_prob_scorer #(
  parameter int ALPHABET    = 27,
  parameter int LOG_WIDTH   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] table_row, [9:5] table_col, [25:10] table_value, [33:26] char_code, rest zero
  input  logic [39:0] in_tdata,
  // [0] command
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] avg_log_prob, [31:16] transition_count
  output logic [31:0] out_tdata
);

  localparam int DEPTH  = ALPHABET * ALPHABET;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IW     = bls_pkg::IDX_W;
  localparam int SW     = bls_pkg::SUM_W;
  localparam int FW     = bls_pkg::FIELD_W;
  localparam logic signed [SW:0] LOG_MAX = (33'sd1 <<< (LOG_WIDTH - 1)) - 33'sd1;
  localparam logic signed [SW:0] LOG_MIN = -LOG_MAX - 33'sd1;
  localparam logic signed [SW:0] SUM_MAX = (33'sd1 <<< (SW - 1)) - 33'sd1;
  localparam logic signed [SW:0] SUM_MIN = -SUM_MAX - 33'sd1;

  bls_pkg::state_t state_r, state_nxt;

  // latched word
  logic                                   cmd_r;
  logic [IW-1:0]                          row_r, col_r;
  logic signed [bls_pkg::VALUE_W-1:0]     val_r;
  logic [7:0]                             code_r;
  logic                                   last_r;

  // line state
  logic [IW-1:0]          prev_r, prev_nxt;
  logic                   have_prev_r, have_prev_nxt;
  logic signed [SW-1:0]   sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic          out_valid_r;
  logic [31:0]   out_data_r;

  bls_pkg::char_hit_t        hit;
  logic                      hit_ok;
  logic                      wr_in_range;
  bls_pkg::ram_ctl_t         ram_ctl;
  logic [ADDR_W-1:0]         ram_addr;
  logic [LOG_WIDTH-1:0]      ram_wdata;
  logic [LOG_WIDTH-1:0]      ram_rdata;
  logic signed [SW:0]        val_ext, val_sat;
  logic signed [SW:0]        acc_sum, acc_sat;
  logic                      div_start;
  bls_pkg::div_sts_t         div_sts;
  logic signed [SW-1:0]      quotient;
  logic signed [SW:0]        q_ext, q_sat;
  logic [COUNT_WIDTH-1:0]    divisor;
  logic                      load_out;

  assign hit    = bls_pkg::char_lookup(code_r);
  assign hit_ok = hit.hit && (bls_pkg::CMP_W'(hit.idx) < bls_pkg::CMP_W'(ALPHABET));
  assign wr_in_range = (bls_pkg::CMP_W'(row_r) < bls_pkg::CMP_W'(ALPHABET)) &&
                       (bls_pkg::CMP_W'(col_r) < bls_pkg::CMP_W'(ALPHABET));

  // table write value saturated to LOG_WIDTH
  assign val_ext   = (SW + 1)'(val_r);
  assign val_sat   = (val_ext > LOG_MAX) ? LOG_MAX : (val_ext < LOG_MIN) ? LOG_MIN : val_ext;
  assign ram_wdata = val_sat[LOG_WIDTH-1:0];

  assign ram_addr = (cmd_r == bls_pkg::CMD_WRITE) ?
                    ADDR_W'(int'(row_r) * ALPHABET + int'(col_r)) :
                    ADDR_W'(int'(prev_r) * ALPHABET + int'(hit.idx));

  bls_table_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (LOG_WIDTH)
  ) u_table (
    .clk   (clk),
    .ctl   (ram_ctl),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign acc_sum = (SW + 1)'(sum_r) + (SW + 1)'($signed(ram_rdata));
  assign acc_sat = (acc_sum > SUM_MAX) ? SUM_MAX : (acc_sum < SUM_MIN) ? SUM_MIN : acc_sum;

  assign divisor = (count_r == '0) ? COUNT_WIDTH'(1) : count_r;

  bls_divider #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (divisor),
    .sts      (div_sts),
    .quotient (quotient)
  );

  assign q_ext = (SW + 1)'(quotient);
  assign q_sat = (q_ext > LOG_MAX) ? LOG_MAX : (q_ext < LOG_MIN) ? LOG_MIN : q_ext;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bls_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = bls_pkg::ST_DECODE;
      end
      bls_pkg::ST_DECODE: begin
        if (cmd_r == bls_pkg::CMD_WRITE) begin
          state_nxt = bls_pkg::ST_IDLE;
        end else if (hit_ok && have_prev_r) begin
          state_nxt = bls_pkg::ST_ACC;
        end else if (last_r) begin
          state_nxt = bls_pkg::ST_DIV_START;
        end else begin
          state_nxt = bls_pkg::ST_IDLE;
        end
      end
      bls_pkg::ST_ACC: begin
        state_nxt = last_r ? bls_pkg::ST_DIV_START : bls_pkg::ST_IDLE;
      end
      bls_pkg::ST_DIV_START: begin
        state_nxt = bls_pkg::ST_DIV_WAIT;
      end
      bls_pkg::ST_DIV_WAIT: begin
        if (div_sts.done) state_nxt = bls_pkg::ST_FINISH;
      end
      bls_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) state_nxt = bls_pkg::ST_IDLE;
      end
      default: state_nxt = bls_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    ram_ctl.we = 1'b0;
    ram_ctl.re = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      bls_pkg::ST_IDLE: in_tready = 1'b1;
      bls_pkg::ST_DECODE: begin
        ram_ctl.we = (cmd_r == bls_pkg::CMD_WRITE) && wr_in_range;
        ram_ctl.re = (cmd_r == bls_pkg::CMD_SCORE) && hit_ok && have_prev_r;
      end
      bls_pkg::ST_DIV_START: div_start = 1'b1;
      bls_pkg::ST_FINISH: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // line state update
  always_comb begin
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    if (state_r == bls_pkg::ST_DECODE && cmd_r == bls_pkg::CMD_SCORE &&
        hit_ok && !have_prev_r) begin
      prev_nxt      = hit.idx;
      have_prev_nxt = 1'b1;
    end
    if (state_r == bls_pkg::ST_ACC) begin
      prev_nxt = hit.idx;
      sum_nxt  = acc_sat[SW-1:0];
      if (count_r != '1) count_nxt = count_r + 1'b1;
    end
    if (load_out) begin
      prev_nxt      = '0;
      have_prev_nxt = 1'b0;
      sum_nxt       = '0;
      count_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bls_pkg::ST_IDLE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      row_r  <= in_tdata[4:0];
      col_r  <= in_tdata[9:5];
      val_r  <= in_tdata[25:10];
      code_r <= in_tdata[33:26];
      last_r <= in_tlast;
    end
    if (load_out) begin
      out_data_r <= {FW'(count_r), q_sat[FW-1:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == bls_pkg::ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending word");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (sum_r == '0 && count_r == '0 && !have_prev_r))
    else $error("line state not cleared after result");

  a_read_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ram_ctl.re |=> state_r == bls_pkg::ST_ACC)
    else $error("table read not followed by accumulate");
`endif

endmodule
